// ----- rtl/tssc_pkg.sv -----
// ============================================================================
// tssc_pkg - shared types and constants for the threshold color select unit
// Holds the pipeline stage map, register indexes and the word layouts.
// ============================================================================
package tssc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF   = 2'd1;

  // divider layout: 17 quotient bits, three restoring steps per stage
  localparam int QUO_W      = 17;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;

  // pipeline stage map
  localparam int ST_FRONT   = 0;
  localparam int ST_DIV0    = 1;
  localparam int ST_F1      = ST_DIV0 + DIV_STAGES;
  localparam int ST_F2      = ST_F1 + 1;
  localparam int ST_F3      = ST_F2 + 1;
  localparam int ST_F4      = ST_F3 + 1;
  localparam int ST_MUL     = ST_F4 + 1;
  localparam int ST_OUT     = ST_MUL + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // fixed point constants
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;

  // four channels, index 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][15:0] color_t;

  // per word sideband that rides along every stage before the output register
  typedef struct packed {
    color_t     lo;
    color_t     hi;
    color_t     diff;
    logic [3:0] hi_ge;
    logic       blend;
    logic       pick_high;
  } side_t;

  // restoring divider state
  typedef struct packed {
    logic [15:0]      rem;
    logic [QUO_W-1:0] nlow;
    logic [15:0]      den;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

// ----- rtl/threshold_smoothstep_color_select_unit.sv -----
// ============================================================================
// threshold_smoothstep_color_select_unit - threshold select with quintic blend
// Picks or blends a low and a high RGBA color from a signed control value.
// ============================================================================
// Stage order is front, divider stages, F1 to F4, multiply and output.
// One word per cycle while out_ready stays high; each stage holds one word and advances
//   when its successor frees up, so bubbles collapse under output stall.
// Reset: synchronous, active low; clears all stage valid bits and both
//   configuration registers (threshold and falloff read as zero).
// ============================================================================
module threshold_smoothstep_color_select_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_low_red,
  input  logic [15:0] in_low_green,
  input  logic [15:0] in_low_blue,
  input  logic [15:0] in_low_alpha,
  input  logic [15:0] in_high_red,
  input  logic [15:0] in_high_green,
  input  logic [15:0] in_high_blue,
  input  logic [15:0] in_high_alpha,
  input  logic signed [15:0] in_control_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha
);
  import tssc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Only the front stage reads them; write them
  // while the block is idle.
  // --------------------------------------------------------------------------
  logic signed [15:0] thr_r;
  logic signed [15:0] fo_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      fo_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_data;
        REG_FALLOFF:   fo_r  <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage control. Each stage loads when it is empty or its successor
  // advances; the output stage advances when the consumer takes the word.
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[ST_OUT] = !v_r[ST_OUT] || out_ready;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[ST_FRONT];
  assign out_valid = v_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[ST_FRONT]) begin
        v_r[ST_FRONT] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Front stage: band bounds, mode decision, dividend and channel deltas.
  // Bounds are kept at 18 bits so threshold +/- falloff never wraps.
  // --------------------------------------------------------------------------
  logic signed [17:0] thr_x;
  logic signed [17:0] fo_x;
  logic signed [17:0] ctl_x;
  logic signed [17:0] lower;
  logic signed [17:0] upper;
  logic [17:0]        num;
  logic [31:0]        dividend;
  logic               fo_pos;
  color_t             lo_in;
  color_t             hi_in;
  side_t              side_nxt;
  div_t               div_front_nxt;

  assign lo_in = {in_low_alpha, in_low_blue, in_low_green, in_low_red};
  assign hi_in = {in_high_alpha, in_high_blue, in_high_green, in_high_red};

  always_comb begin
    thr_x  = {{2{thr_r[15]}}, thr_r};
    fo_x   = {{2{fo_r[15]}}, fo_r};
    ctl_x  = {{2{in_control_value[15]}}, in_control_value};
    lower  = thr_x - fo_x;
    upper  = thr_x + fo_x;
    fo_pos = (fo_r > 16'sd0);

    side_nxt.lo = lo_in;
    side_nxt.hi = hi_in;
    for (int c = 0; c < 4; c++) begin
      side_nxt.hi_ge[c] = (hi_in[c] >= lo_in[c]);
      side_nxt.diff[c]  = side_nxt.hi_ge[c] ? (hi_in[c] - lo_in[c]) : (lo_in[c] - hi_in[c]);
    end

    if (!fo_pos) begin
      // hard switch: equal to the threshold picks high
      side_nxt.blend     = 1'b0;
      side_nxt.pick_high = !(ctl_x < thr_x);
    end else begin
      side_nxt.blend     = !(ctl_x < lower) && !(ctl_x > upper);
      side_nxt.pick_high = (ctl_x > upper);
    end

    // t = (num * 2^16 + falloff) / (2 * falloff), rounded to nearest.
    // Inside the band num <= 2*falloff, so the dividend fits 32 bits and
    // its top 15 bits are already below the divisor.
    num      = ctl_x - lower;
    dividend = {num[15:0], 16'h0000} + {17'h0_0000, fo_r[14:0]};

    div_front_nxt.rem  = {1'b0, dividend[31:17]};
    div_front_nxt.nlow = dividend[16:0];
    div_front_nxt.den  = {fo_r[14:0], 1'b0};
    div_front_nxt.quo  = '0;
  end

  side_t side_r [ST_OUT];
  div_t  div_q  [DIV_STAGES+1];
  div_t  div_front_r;

  always_ff @(posedge clk) begin
    if (adv[ST_FRONT]) begin
      side_r[ST_FRONT] <= side_nxt;
      div_front_r      <= div_front_nxt;
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (adv[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign div_q[0] = div_front_r;

  // --------------------------------------------------------------------------
  // Divider: DIV_STAGES stages, three quotient bits each (the last stage two), MSB first.
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int FB = QUO_W - 1 - DIV_STEP * s;
    localparam int NB = (FB + 1 < DIV_STEP) ? FB + 1 : DIV_STEP;

    tssc_div_stage #(
      .FIRST_BIT (FB),
      .NUM_BITS  (NB)
    ) u_div_stage (
      .clk     (clk),
      .load    (adv[ST_DIV0+s]),
      .div_in  (div_q[s]),
      .div_out (div_q[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // Fade 6t^5 - 15t^4 + 10t^3 as t3 * p, with p = 6t^2 - 15t + 10.
  // Every rounding adds half an LSB and drops 16 bits.
  // --------------------------------------------------------------------------
  logic [16:0] t_nxt;
  logic [33:0] tt_full;
  logic [16:0] t1_r;
  logic [32:0] tt_r;

  always_comb begin
    t_nxt   = (div_q[DIV_STAGES].quo > ONE_Q16) ? ONE_Q16 : div_q[DIV_STAGES].quo;
    tt_full = t_nxt * t_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_F1]) begin
      t1_r <= t_nxt;
      tt_r <= tt_full[32:0];
    end
  end

  // F2: t3 product and p in parallel
  logic [33:0] tt_rnd;
  logic [16:0] t2;
  logic [33:0] t3p_full;
  logic [36:0] poly;
  logic [32:0] t3p_r;
  logic [19:0] p_r;

  always_comb begin
    tt_rnd   = {1'b0, tt_r} + {18'h0, HALF_Q16};
    t2       = tt_rnd[32:16];
    t3p_full = t2 * t1_r;
    poly     = ({2'b00, tt_r, 2'b00} + {3'b000, tt_r, 1'b0} + {37'd10 << 32})
             - ({t1_r, 20'h0_0000} - {4'h0, t1_r, 16'h0000})
             + {21'h0, HALF_Q16};
  end

  always_ff @(posedge clk) begin
    if (adv[ST_F2]) begin
      t3p_r <= t3p_full[32:0];
      p_r   <= poly[35:16];
    end
  end

  // F3: fade product
  logic [33:0] t3_rnd;
  logic [16:0] t3;
  logic [36:0] fp_nxt;
  logic [36:0] fp_r;

  always_comb begin
    t3_rnd = {1'b0, t3p_r} + {18'h0, HALF_Q16};
    t3     = t3_rnd[32:16];
    fp_nxt = t3 * p_r;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_F3]) begin
      fp_r <= fp_nxt;
    end
  end

  // F4: round and saturate to 1.0
  logic [37:0] fp_rnd;
  logic [16:0] fade_nxt;
  logic [16:0] fade_r;

  always_comb begin
    fp_rnd   = {1'b0, fp_r} + {22'h0, HALF_Q16};
    fade_nxt = (fp_rnd[37:16] > {5'h00, ONE_Q16}) ? ONE_Q16 : fp_rnd[32:16];
  end

  always_ff @(posedge clk) begin
    if (adv[ST_F4]) begin
      fade_r <= fade_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Channel blend: four lanes of fade * |high - low|, then add or subtract.
  // --------------------------------------------------------------------------
  logic [3:0][32:0] prod_nxt;
  logic [3:0][32:0] prod_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod_nxt[c] = fade_r * side_r[ST_F4].diff[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      prod_r <= prod_nxt;
    end
  end

  logic [33:0] m_rnd [4];
  color_t      out_nxt;
  color_t      out_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      m_rnd[c] = {1'b0, prod_r[c]} + {18'h0, HALF_Q16};
      if (side_r[ST_MUL].blend) begin
        out_nxt[c] = side_r[ST_MUL].hi_ge[c] ? (side_r[ST_MUL].lo[c] + m_rnd[c][31:16])
                                             : (side_r[ST_MUL].lo[c] - m_rnd[c][31:16]);
      end else begin
        out_nxt[c] = side_r[ST_MUL].pick_high ? side_r[ST_MUL].hi[c] : side_r[ST_MUL].lo[c];
      end
    end
  end

  // output register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];
  assign out_alpha = out_r[3];

endmodule

// ----- rtl/tssc_div_stage.sv -----
// ============================================================================
// tssc_div_stage - one registered stage of the restoring divider
// Resolves NUM_BITS quotient bits from FIRST_BIT downward.
// ============================================================================
module tssc_div_stage #(
  parameter int FIRST_BIT = 16,
  parameter int NUM_BITS  = 3
) (
  input  logic            clk,
  input  logic            load,
  input  tssc_pkg::div_t  div_in,
  output tssc_pkg::div_t  div_out
);
  import tssc_pkg::*;

  div_t        div_r;
  div_t        div_nxt;
  logic [16:0] part;

  always_comb begin
    div_nxt = div_in;
    part    = '0;
    for (int j = 0; j < NUM_BITS; j++) begin
      part = {div_nxt.rem, div_nxt.nlow[FIRST_BIT-j]};
      if (part >= {1'b0, div_nxt.den}) begin
        part = part - {1'b0, div_nxt.den};
        div_nxt.quo[FIRST_BIT-j] = 1'b1;
      end
      div_nxt.rem = part[15:0];
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      div_r <= div_nxt;
    end
  end

  assign div_out = div_r;

endmodule

// ----- rtl/tssc_checker.sv -----
// ============================================================================
// tssc_checker - port level checks for the threshold color select unit
// Watches handshakes and stall behavior; attached to the top level by bind.
// ============================================================================
module tssc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue,
  input logic [15:0] out_alpha
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
                                && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result word changed or dropped");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output stage lets every stage advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // configuration writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind threshold_smoothstep_color_select_unit tssc_checker u_tssc_checker (.*);

// ----- bench/threshold_smoothstep_color_select_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color select checker
// Tracks the threshold and falloff registers from the configuration
// channel. Computes the selected or blended pixel for every accepted input
// word. Compares each accepted output word with the oldest pending pixel.
// ----------------------------------------------------------------------------
module threshold_smoothstep_color_select_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [15:0]                   in_low_red,
  input  logic [15:0]                   in_low_green,
  input  logic [15:0]                   in_low_blue,
  input  logic [15:0]                   in_low_alpha,
  input  logic [15:0]                   in_high_red,
  input  logic [15:0]                   in_high_green,
  input  logic [15:0]                   in_high_blue,
  input  logic [15:0]                   in_high_alpha,
  input  logic signed [15:0]            in_control_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [15:0]                   out_red,
  input  logic [15:0]                   out_green,
  input  logic [15:0]                   out_blue,
  input  logic [15:0]                   out_alpha,
  output int                            mismatch_count,
  output int                            pending_words
);
  import tssc_pkg::*;

  logic signed [15:0] threshold_copy;
  logic signed [15:0] falloff_copy;
  color_t             expected_colors [$];

  initial mismatch_count = 0;

  // round a Q32 product back to Q16, ties up
  function automatic longint unsigned round_q16(input longint unsigned v);
    return (v + 64'd32768) >> 16;
  endfunction

  // 6t^5 - 15t^4 + 10t^3 in Q16, saturated to 1.0
  function automatic longint unsigned quintic_fade(input longint unsigned t);
    longint unsigned t2, t3, p, f;
    t2 = round_q16(t * t);
    t3 = round_q16(t2 * t);
    p  = round_q16(64'd6 * t * t + (64'd10 << 32) - 64'd15 * t * 64'd65536);
    f  = round_q16(t3 * p);
    if (f > 64'd65536) f = 64'd65536;
    return f;
  endfunction

  function automatic color_t selected_color(input color_t lo, input color_t hi,
                                            input logic signed [15:0] ctl,
                                            input logic signed [15:0] thr,
                                            input logic signed [15:0] fall);
    int              c, th, fw, lower, upper, k;
    longint unsigned num, den, t, fade, d;
    color_t          res;
    c     = ctl;
    th    = thr;
    fw    = fall;
    lower = th - fw;
    upper = th + fw;
    if (fw <= 0) begin
      res = (c < th) ? lo : hi;
    end else if (c < lower) begin
      res = lo;
    end else if (c > upper) begin
      res = hi;
    end else begin
      num = c - lower;
      den = 2 * fw;
      t   = (num * 64'd65536 + fw) / den;
      if (t > 64'd65536) t = 64'd65536;
      fade = quintic_fade(t);
      for (k = 0; k < 4; k++) begin
        if (hi[k] >= lo[k]) begin
          d      = hi[k] - lo[k];
          res[k] = lo[k] + 16'(round_q16(fade * d));
        end else begin
          d      = lo[k] - hi[k];
          res[k] = lo[k] - 16'(round_q16(fade * d));
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    color_t want, got;
    logic   in_fire, out_fire;
    int     k;
    in_fire  = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    if (!rst_n) begin
      threshold_copy <= '0;
      falloff_copy   <= '0;
      pending_words  <= 0;
      expected_colors.delete();
    end else begin
      // registers only change while the pipe is empty
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: threshold_copy <= cfg_data;
          REG_FALLOFF:   falloff_copy   <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        expected_colors.push_back(selected_color(
          {in_low_alpha, in_low_blue, in_low_green, in_low_red},
          {in_high_alpha, in_high_blue, in_high_green, in_high_red},
          in_control_value, threshold_copy, falloff_copy));
      end
      if (out_fire) begin
        got = {out_alpha, out_blue, out_green, out_red};
        if (expected_colors.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected output word %h", $time, got);
        end else begin
          want = expected_colors.pop_front();
          for (k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              mismatch_count++;
              $display("%0t: channel %0d (0 red, 1 green, 2 blue, 3 alpha) expected %h got %h",
                       $time, k, want[k], got[k]);
            end
          end
        end
      end
      pending_words <= expected_colors.size();
    end
  end

endmodule

// ----- bench/threshold_smoothstep_color_select_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Threshold smoothstep color select unit testbench
// Drives directed corner pixels, then random pixels under a series of
// threshold and falloff settings with varying sender gaps and receiver
// stalls; a side checker predicts every output word and counts mismatches.
// ----------------------------------------------------------------------------
module threshold_smoothstep_color_select_unit_tb;
  import tssc_pkg::*;

  // register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES    = 40;    // well past the pipeline latency
  localparam int RUN_LIMIT_NS    = 2_000_000;

  // idling profiles per phase
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  logic               in_valid, in_ready;
  logic [15:0]        in_low_red, in_low_green, in_low_blue, in_low_alpha;
  logic [15:0]        in_high_red, in_high_green, in_high_blue, in_high_alpha;
  logic signed [15:0] in_control_value;

  logic        out_valid, out_ready;
  logic [15:0] out_red, out_green, out_blue, out_alpha;

  int mismatch_count;
  int pending_words;

  // stimulus knobs
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int cur_threshold  = 0;
  int cur_falloff    = 0;

  always #5 clk = ~clk;

  threshold_smoothstep_color_select_unit DUT (.*);

  threshold_smoothstep_color_select_checker checker_i (.*);

  // Run the limit watchdog independently of the stimulus.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold until every expected word has come back; the pipe is empty then,
  // because every input word yields exactly one output word.
  task automatic wait_drained();
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Issue one register write; leave cfg_valid up so back-to-back writes
  // never see it dropped and raised in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprogram both registers while idle. Optionally poke the unused
  // indexes to show they change nothing.
  task automatic apply_config(input int thr, input int fall, input bit poke_spare);
    wait_drained();
    write_reg(REG_THRESHOLD, 16'(thr));
    write_reg(REG_FALLOFF, 16'(fall));
    if (poke_spare) begin
      write_reg(REG_SPARE_A, 16'hFFFF);
      write_reg(REG_SPARE_B, 16'h7FFF);
    end
    cfg_valid <= 1'b0;
    cur_threshold = thr;
    cur_falloff   = fall;
  endtask

  // Offer one pixel after a random gap; return at the accepting edge with
  // in_valid still high.
  task automatic send_pixel(input color_t lo, input color_t hi, input logic [15:0] ctl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_low_red       <= lo[0];
    in_low_green     <= lo[1];
    in_low_blue      <= lo[2];
    in_low_alpha     <= lo[3];
    in_high_red      <= hi[0];
    in_high_green    <= hi[1];
    in_high_blue     <= hi[2];
    in_high_alpha    <= hi[3];
    in_control_value <= ctl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly full-range colors, with some rails and some flat channels.
  function automatic color_t random_color(input int mode);
    color_t c;
    int     k;
    for (k = 0; k < 4; k++) begin
      if (mode == 1) c[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else           c[k] = 16'($urandom);
    end
    return c;
  endfunction

  // Aim most control values at the band (or the switch point) and its
  // edges; the rest spread over the whole range.
  task automatic send_random_pixel();
    color_t lo, hi;
    int     mode, v;
    mode = $urandom_range(9);
    lo   = random_color(mode);
    hi   = (mode == 0) ? lo : random_color(mode);
    if ($urandom_range(99) < 70) begin
      if (cur_falloff > 0) v = cur_threshold - cur_falloff - 3 + $urandom_range(2 * cur_falloff + 6);
      else                 v = cur_threshold - 4 + $urandom_range(8);
      if (v < -32768) v = -32768;
      if (v > 32767)  v = 32767;
    end else begin
      v = $signed(16'($urandom));
    end
    send_pixel(lo, hi, 16'(v));
  endtask

  // One setting of the registers with a given idling profile.
  task automatic run_phase(input int thr, input int fall, input int idle_mode,
                           input bit with_hold);
    int n;
    apply_config(thr, fall, 1'b0);
    send_idle_pct  = (idle_mode == IDLE_SEND) ? 86 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    recv_stall_pct = (idle_mode == IDLE_RECV) ? 86 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    if (with_hold) hold_request = 1'b1;
    for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_pixel();
    in_valid <= 1'b0;
  endtask

  initial begin
    color_t             black, white, mixed;
    logic signed [15:0] r_thr, r_fall;
    int                 n;
    black = '0;
    white = '1;
    mixed = {16'h1234, 16'hFFFF, 16'h0000, 16'h8001};

    // Drive every input to a known value, then hold reset.
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_low_red       <= '0;
    in_low_green     <= '0;
    in_low_blue      <= '0;
    in_low_alpha     <= '0;
    in_high_red      <= '0;
    in_high_green    <= '0;
    in_high_blue     <= '0;
    in_high_alpha    <= '0;
    in_control_value <= '0;
    out_ready        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hard switch at reset values: below zero picks low, zero itself
    // picks high, plus both rails of the control range.
    send_pixel(black, white, -16'sd1);
    send_pixel(black, white, 16'sd0);
    send_pixel(white, black, -16'sd32768);
    send_pixel(white, black, 16'sd32767);
    in_valid <= 1'b0;

    // Blend band 0x0400..0x0C00; spare indexes must be ignored.
    apply_config(16'h0800, 16'h0400, 1'b1);
    send_pixel(white, black, 16'sh0400);          // lower edge: exactly low
    send_pixel(white, black, 16'sh0C00);          // upper edge: exactly high
    send_pixel(black, white, 16'sh03FF);          // just below the band
    send_pixel(black, white, 16'sh0C01);          // just above the band
    send_pixel(black, white, 16'sh0800);          // midpoint
    send_pixel(mixed, mixed, 16'sh0900);          // flat channels
    send_pixel(mixed, ~mixed, 16'sh0555);
    send_pixel(~mixed, mixed, 16'sh0A3C);
    send_pixel(white, mixed, 16'sh0401);
    in_valid <= 1'b0;

    // Negative falloff still switches hard at the threshold.
    apply_config(32767, -32768, 1'b0);
    send_pixel(mixed, ~mixed, 16'sd32767);
    send_pixel(mixed, ~mixed, 16'sd32766);
    in_valid <= 1'b0;

    // Random phases; the first one also holds the receiver off long enough
    // for the pipe to fill and push back on the sender.
    run_phase(16'h1000, 16'h0800, IDLE_NONE, 1'b1);
    run_phase(-32768, 32767, IDLE_SEND, 1'b0);
    run_phase(32767, 32767, IDLE_RECV, 1'b0);
    run_phase(0, 1, IDLE_BOTH, 1'b0);
    run_phase(32767, -32768, IDLE_NONE, 1'b0);
    run_phase(-32768, 0, IDLE_SEND, 1'b0);
    run_phase(-1024, 128, IDLE_RECV, 1'b0);
    for (n = 0; n < 2; n++) begin
      r_thr  = 16'($urandom);
      r_fall = (n == 0) ? 16'($urandom_range(2048, 1)) : 16'($urandom);
      run_phase(r_thr, r_fall, (n == 0) ? IDLE_BOTH : IDLE_NONE, 1'b0);
    end

    // Drain, give the pipe time to show any stray word, then judge.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
